### src/smtk_pkg.sv
package smtk_pkg;

  localparam int MaxClasses = 64;
  localparam int TopKMax    = 5;

  function automatic logic [16:0] exp_int(input logic [3:0] ip);
    case (ip)
      4'd0:    exp_int = 17'd65536;
      4'd1:    exp_int = 17'd24109;
      4'd2:    exp_int = 17'd8869;
      4'd3:    exp_int = 17'd3263;
      4'd4:    exp_int = 17'd1200;
      4'd5:    exp_int = 17'd442;
      4'd6:    exp_int = 17'd162;
      4'd7:    exp_int = 17'd60;
      4'd8:    exp_int = 17'd22;
      4'd9:    exp_int = 17'd8;
      4'd10:   exp_int = 17'd3;
      4'd11:   exp_int = 17'd1;
      default: exp_int = 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] exp_hi(input logic [3:0] h);
    case (h)
      4'd0:    exp_hi = 17'd65536;
      4'd1:    exp_hi = 17'd61565;
      4'd2:    exp_hi = 17'd57836;
      4'd3:    exp_hi = 17'd54332;
      4'd4:    exp_hi = 17'd51039;
      4'd5:    exp_hi = 17'd47947;
      4'd6:    exp_hi = 17'd45042;
      4'd7:    exp_hi = 17'd42313;
      4'd8:    exp_hi = 17'd39750;
      4'd9:    exp_hi = 17'd37341;
      4'd10:   exp_hi = 17'd35079;
      4'd11:   exp_hi = 17'd32954;
      4'd12:   exp_hi = 17'd30957;
      4'd13:   exp_hi = 17'd29081;
      4'd14:   exp_hi = 17'd27319;
      default: exp_hi = 17'd25664;
    endcase
  endfunction

  function automatic logic [16:0] exp_lo(input logic [3:0] l);
    case (l)
      4'd0:    exp_lo = 17'd65536;
      4'd1:    exp_lo = 17'd65280;
      4'd2:    exp_lo = 17'd65026;
      4'd3:    exp_lo = 17'd64772;
      4'd4:    exp_lo = 17'd64520;
      4'd5:    exp_lo = 17'd64268;
      4'd6:    exp_lo = 17'd64018;
      4'd7:    exp_lo = 17'd63768;
      4'd8:    exp_lo = 17'd63520;
      4'd9:    exp_lo = 17'd63272;
      4'd10:   exp_lo = 17'd63025;
      4'd11:   exp_lo = 17'd62780;
      4'd12:   exp_lo = 17'd62535;
      4'd13:   exp_lo = 17'd62291;
      4'd14:   exp_lo = 17'd62048;
      default: exp_lo = 17'd61806;
    endcase
  endfunction

  typedef struct packed {
    logic [2:0]  rank;
    logic [5:0]  class_index;
    logic [15:0] probability;
    logic        last_rank;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [22:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

### src/smtk_if.sv
interface smtk_logit_if;
  logic        valid;
  logic        ready;
  logic [15:0] logit_value;
  logic        last_logit;
  modport source (output valid, logit_value, last_logit, input ready);
  modport sink (input valid, logit_value, last_logit, output ready);
endinterface

interface smtk_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  rank;
  logic [5:0]  class_index;
  logic [15:0] probability;
  logic        last_rank;
  modport source (output valid, rank, class_index, probability, last_rank, input ready);
  modport sink (input valid, rank, class_index, probability, last_rank, output ready);
endinterface

interface smtk_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/smtk_ram.sv
module smtk_ram #(
  parameter int Depth = 64,
  parameter int Width = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/smtk_div.sv
module smtk_div (
  input  logic                clk,
  input  logic                rst,
  input  smtk_pkg::div_req_t  req,
  output smtk_pkg::div_rsp_t  rsp
);
  // Restoring divider, one quotient bit per cycle.
  logic [31:0] quot;
  logic [23:0] rem;
  logic [22:0] dvs;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [23:0] trial;
  logic [24:0] diff;

  assign trial = {rem[22:0], quot[31]};
  assign diff  = {1'b0, trial} - {2'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quot <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= 6'd32;
      end else if (busy) begin
        if (diff[24]) begin
          rem  <= trial;
          quot <= {quot[30:0], 1'b0};
        end else begin
          rem  <= diff[23:0];
          quot <= {quot[30:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quot};
endmodule

### src/softmax_top_k_select_core.sv
// Softmax with top-k selection over a set of up to 64 class logits.
//
// Logits enter on the in channel, one item per cycle, as signed Q8.8 values
// in class order. The item with last_logit set closes the set; logits past
// the 64th are dropped. The block then walks its logit memory to compute
// exp(logit - max) from three small tables, adds up the sum, divides each
// exponential by the sum with a serial divider, and finally runs one scan
// of the probability memory per reported rank. While it computes, in.ready
// is low. Results leave on the out channel, one item per rank, best first,
// with last_rank on the final one. The output register holds a result until
// the receiver takes it; the next rank waits meanwhile, so no result is lost.
// The top_count register is written on the cfg channel, which is always
// ready; it should be written only while the block is idle.
// Reset clears the class count, running maximum, picked mask and sets
// top_count to 5. The memories need no clearing: only written entries are read.
module softmax_top_k_select_core (
  input logic clk,
  input logic rst,
  smtk_logit_if.sink    in,
  smtk_result_if.source out,
  smtk_cfg_if.sink      cfg
);
  typedef enum logic [3:0] {
    S_LOAD, S_EXP_RD, S_EXP_MUL, S_EXP_LO, S_EXP_ACC, S_DIV_RD, S_DIV_START,
    S_DIV_WAIT, S_DIV_WR, S_SEL_RD, S_SEL_SCAN, S_SEL_OUT
  } state_t;

  state_t      state;
  logic [2:0]  top_count;
  logic [6:0]  class_count;
  logic signed [15:0] running_max;
  logic [63:0] picked_mask;
  logic [22:0] sum;
  logic [5:0]  idx;
  logic [2:0]  rank;
  logic [2:0]  k_eff;
  logic [15:0] best_prob;
  logic [5:0]  best_idx;
  logic        found;
  logic [33:0] prod;
  logic [15:0] d_reg;
  smtk_pkg::div_req_t div_req;
  smtk_pkg::div_rsp_t div_rsp;

  // Logit memory.
  logic        lg_we;
  logic [5:0]  lg_waddr, lg_raddr;
  logic [15:0] lg_rdata;
  // Probability memory.
  logic        pr_we;
  logic [5:0]  pr_waddr, pr_raddr;
  logic [15:0] pr_wdata, pr_rdata;

  smtk_ram #(.Depth(smtk_pkg::MaxClasses), .Width(16)) u_logit_ram (
    .clk(clk), .we(lg_we), .waddr(lg_waddr), .wdata(in.logit_value),
    .raddr(lg_raddr), .rdata(lg_rdata)
  );
  smtk_ram #(.Depth(smtk_pkg::MaxClasses), .Width(16)) u_prob_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_rdata)
  );
  smtk_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign in.ready  = (state == S_LOAD);
  assign cfg.ready = 1'b1;

  logic in_fire;
  logic room;
  assign in_fire = in.valid && in.ready;
  assign room    = (class_count < 7'(smtk_pkg::MaxClasses));
  assign lg_we    = in_fire && room;
  assign lg_waddr = class_count[5:0];
  assign lg_raddr = idx;
  assign pr_raddr = idx;

  // Difference max - logit, always nonnegative.
  logic [16:0] d_full;
  assign d_full = 17'($signed({running_max[15], running_max})
                  - $signed({lg_rdata[15], lg_rdata}));

  // Effective rank count.
  logic [2:0] k_cfg;
  always_comb begin
    k_cfg = top_count;
    if (k_cfg == 3'd0) k_cfg = 3'd1;
    if (k_cfg > 3'(smtk_pkg::TopKMax)) k_cfg = 3'(smtk_pkg::TopKMax);
  end

  logic [31:0] e_t;
  logic [15:0] e_sat;
  assign e_t   = prod[33:16] > 18'd65535 ? 32'd65535 : 32'(prod[33:16]);
  assign e_sat = e_t[15:0];

  always_comb begin
    pr_we    = 1'b0;
    pr_waddr = idx;
    pr_wdata = e_sat;
    if (state == S_EXP_ACC) begin
      pr_we = 1'b1;
    end else if (state == S_DIV_WR) begin
      pr_we    = 1'b1;
      pr_wdata = (div_rsp.quotient > 32'd65535) ? 16'hFFFF : div_rsp.quotient[15:0];
    end
  end

  logic last_idx;
  assign last_idx = ({1'b0, idx} == class_count - 7'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_LOAD;
      top_count   <= 3'd5;
      class_count <= '0;
      running_max <= 16'sh8000;
      picked_mask <= '0;
      out.valid   <= 1'b0;
      div_req.start <= 1'b0;
      idx         <= '0;
    end else begin
      // The divider starts the cycle after the dividend is read.
      div_req.start <= (state == S_DIV_START);
      if (cfg.valid) begin
        top_count <= cfg.data;
      end
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (room) begin
              class_count <= class_count + 7'd1;
              if ($signed(in.logit_value) > running_max) begin
                running_max <= $signed(in.logit_value);
              end
            end
            if (in.last_logit) begin
              idx   <= '0;
              sum   <= '0;
              state <= S_EXP_RD;
            end
          end
        end
        S_EXP_RD: state <= S_EXP_MUL;
        S_EXP_MUL: begin
          // First table product; the second follows next cycle.
          d_reg <= d_full[15:0];
          if (d_full[15:8] >= 8'd12) begin
            prod <= '0;
          end else begin
            prod <= 34'(smtk_pkg::exp_int(d_full[11:8]) * smtk_pkg::exp_hi(d_full[7:4]));
          end
          state <= S_EXP_LO;
        end
        S_EXP_LO: begin
          prod  <= 34'(prod[33:16] * smtk_pkg::exp_lo(d_reg[3:0]));
          state <= S_EXP_ACC;
        end
        S_EXP_ACC: begin
          // The exponential is final now; it is written to memory this cycle.
          sum <= sum + 23'(e_sat);
          if (last_idx) begin
            idx   <= '0;
            state <= S_DIV_RD;
          end else begin
            idx   <= idx + 6'd1;
            state <= S_EXP_RD;
          end
        end
        S_DIV_RD: state <= S_DIV_START;
        S_DIV_START: begin
          div_req.dividend <= {pr_rdata, 16'd0};
          div_req.divisor  <= sum;
          state            <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            state <= S_DIV_WR;
          end
        end
        S_DIV_WR: begin
          if (last_idx) begin
            idx     <= '0;
            rank    <= '0;
            k_eff   <= (7'(k_cfg) > class_count) ? class_count[2:0] : k_cfg;
            found   <= 1'b0;
            state   <= S_SEL_RD;
          end else begin
            idx   <= idx + 6'd1;
            state <= S_DIV_RD;
          end
        end
        S_SEL_RD: begin
          state <= S_SEL_SCAN;
          idx   <= idx + 6'd1;
        end
        S_SEL_SCAN: begin
          // The entry under test is idx - 1, one behind the read address.
          if (!picked_mask[idx - 6'd1] &&
              (!found || pr_rdata > best_prob)) begin
            found     <= 1'b1;
            best_prob <= pr_rdata;
            best_idx  <= idx - 6'd1;
          end
          if ({1'b0, idx - 6'd1} == class_count - 7'd1) begin
            state <= S_SEL_OUT;
          end else begin
            idx <= idx + 6'd1;
          end
        end
        S_SEL_OUT: begin
          if (!out.valid || out.ready) begin
            out.valid       <= 1'b1;
            out.rank        <= rank;
            out.class_index <= best_idx;
            out.probability <= best_prob;
            out.last_rank   <= (rank + 3'd1 == k_eff);
            rank  <= rank + 3'd1;
            found <= 1'b0;
            idx   <= '0;
            if (rank + 3'd1 == k_eff) begin
              class_count <= '0;
              running_max <= 16'sh8000;
              picked_mask <= '0;
              state       <= S_LOAD;
            end else begin
              picked_mask[best_idx] <= 1'b1;
              state <= S_SEL_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      if (out.valid && out.ready && state != S_SEL_OUT) begin
        out.valid <= 1'b0;
      end
    end
  end
endmodule

### tb/tb_softmax_top_k_select_core.sv
module tb_softmax_top_k_select_core;

  logic clk;
  logic rst;

  smtk_logit_if  logit_ch ();
  smtk_result_if rank_ch ();
  smtk_cfg_if    cfg_ch ();

  softmax_top_k_select_core uut (
    .clk (clk),
    .rst (rst),
    .in  (logit_ch.sink),
    .out (rank_ch.source),
    .cfg (cfg_ch.sink)
  );

  // Exponential tables: exp(-ip), exp(-h/16) and exp(-l/256) in Q16.
  localparam int unsigned ExpWhole[12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                           162, 60, 22, 8, 3, 1};
  localparam int unsigned ExpSixteenth[16] = '{65536, 61565, 57836, 54332, 51039,
    47947, 45042, 42313, 39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
  localparam int unsigned ExpFine[16] = '{65536, 65280, 65026, 64772, 64520,
    64268, 64018, 63768, 63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};
  localparam longint CycleLimit = 3000000;

  // Predictor state: the logits of the set being collected and the count.
  logic signed [15:0] set_logits[smtk_pkg::MaxClasses];
  int                 set_size;
  logic [2:0]         rank_limit;

  smtk_pkg::result_t rankings_due[$];
  int          error_count;
  longint      cycle_count;
  bit          stall_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The run is ended here once the cycle count passes CycleLimit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned exp_q16(input int unsigned d);
    longint unsigned t;
    if ((d >> 8) >= 12) return 0;
    t = (longint'(ExpWhole[d >> 8]) * ExpSixteenth[(d >> 4) & 15]) >> 16;
    t = (t * ExpFine[d & 15]) >> 16;
    return (t > 65535) ? 65535 : int'(t);
  endfunction

  // Computes the ranked probabilities of the closed set and queues them.
  task automatic rank_closed_set();
    int               peak;
    longint unsigned  sum;
    longint unsigned  q;
    int unsigned      expo[smtk_pkg::MaxClasses];
    int unsigned      prob[smtk_pkg::MaxClasses];
    bit               taken[smtk_pkg::MaxClasses];
    int               k;
    int               best;
    smtk_pkg::result_t r;
    peak = -32768;
    sum = 0;
    for (int i = 0; i < set_size; i++)
      if (int'(set_logits[i]) > peak) peak = set_logits[i];
    for (int i = 0; i < set_size; i++) begin
      expo[i] = exp_q16(peak - int'(set_logits[i]));
      sum += expo[i];
      taken[i] = 1'b0;
    end
    for (int i = 0; i < set_size; i++) begin
      q = (longint'(expo[i]) << 16) / sum;
      prob[i] = (q > 65535) ? 65535 : int'(q);
    end
    k = (rank_limit == 0) ? 1 : rank_limit;
    if (k > smtk_pkg::TopKMax) k = smtk_pkg::TopKMax;
    if (k > set_size) k = set_size;
    for (int j = 0; j < k; j++) begin
      best = -1;
      for (int i = 0; i < set_size; i++)
        if (!taken[i] && (best < 0 || prob[i] > prob[best])) best = i;
      taken[best] = 1'b1;
      r.rank = j[2:0];
      r.class_index = best[5:0];
      r.probability = prob[best][15:0];
      r.last_rank = (j + 1 == k);
      rankings_due.push_back(r);
    end
    set_size = 0;
  endtask

  task automatic report_mismatch(input string what);
    $display("Mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // Checks every accepted ranking against the oldest one predicted.
  always @(posedge clk) begin
    smtk_pkg::result_t got;
    smtk_pkg::result_t want;
    if (!rst && rank_ch.valid && rank_ch.ready) begin
      got = '{rank_ch.rank, rank_ch.class_index, rank_ch.probability,
              rank_ch.last_rank};
      if (rankings_due.size() == 0) begin
        report_mismatch($sformatf("unexpected ranking %p", got));
      end else begin
        want = rankings_due.pop_front();
        if (got.rank != want.rank)
          report_mismatch($sformatf("rank %0d, want %0d", got.rank, want.rank));
        if (got.class_index != want.class_index)
          report_mismatch($sformatf("class %0d, want %0d", got.class_index,
                                    want.class_index));
        if (got.probability != want.probability)
          report_mismatch($sformatf("probability %0d, want %0d", got.probability,
                                    want.probability));
        if (got.last_rank != want.last_rank)
          report_mismatch($sformatf("last_rank %0d, want %0d", got.last_rank,
                                    want.last_rank));
      end
    end
  end

  // The receiver stalls a random number of cycles before each ranking,
  // unless stalls are switched off for a stretch.
  initial begin
    int gap;
    rank_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = stall_out ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        rank_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rank_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rank_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Sends one logit after a gap, and predicts when it closes a set.
  // Valid stays high on return; the next item with a gap, or a drain, takes it down.
  task automatic send_logit(input logic [15:0] value, input bit last, input int gap);
    if (gap > 0) begin
      logit_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    logit_ch.valid <= 1'b1;
    logit_ch.logit_value <= value;
    logit_ch.last_logit <= last;
    @(posedge clk);
    while (!logit_ch.ready) @(posedge clk);
    // Logits past the store capacity are dropped by the block.
    if (set_size < smtk_pkg::MaxClasses) begin
      set_logits[set_size] = value;
      set_size++;
    end
    if (last) rank_closed_set();
    @(negedge clk);
  endtask

  // Waits until every ranking has come and the block has had time to settle.
  task automatic drain();
    logit_ch.valid <= 1'b0;
    while (rankings_due.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_top_count(input logic [2:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    rank_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Sends a whole set of n logits with values drawn from a given spread.
  task automatic send_random_set(input int n, input int spread, input bit gaps);
    int base;
    int v;
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < n; i++) begin
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      send_logit(v[15:0], i == n - 1, gaps ? $urandom_range(0, 12) : 0);
    end
  endtask

  // Extreme logits, a single-class set and exact ties that test the
  // lower-index rule.
  task automatic test_directed_extremes();
    write_top_count(3'd5);
    send_logit(16'h7fff, 1'b0, 0);
    send_logit(16'h8000, 1'b0, 1);
    send_logit(16'h0000, 1'b0, 0);
    send_logit(16'hffff, 1'b0, 2);
    send_logit(16'h5555, 1'b0, 0);
    send_logit(16'haaaa, 1'b1, 0);
    send_logit(16'h0100, 1'b1, 0);
    for (int i = 0; i < 4; i++) send_logit(16'h0200, i == 3, 0);
    send_logit(16'h0000, 1'b0, 0);
    send_logit(16'hf400, 1'b0, 0);
    send_logit(16'hf401, 1'b0, 0);
    send_logit(16'h0001, 1'b1, 0);
    drain();
  endtask

  // Every top_count setting, including zero and the values above the limit.
  task automatic test_top_count_settings();
    logic [2:0] setting;
    for (int s = 0; s < 8; s++) begin
      setting = s[2:0];
      write_top_count(setting);
      send_random_set(7, 600, 1'b1);
      drain();
    end
    // Fewer classes than ranks asked for.
    write_top_count(3'd5);
    send_random_set(2, 300, 1'b0);
    drain();
  endtask

  // A full store plus dropped logits, one of which closes the set.
  task automatic test_store_overflow();
    write_top_count(3'd4);
    for (int i = 0; i < smtk_pkg::MaxClasses + 3; i++)
      send_logit(16'($urandom_range(0, 65535)), i == smtk_pkg::MaxClasses + 2,
                 $urandom_range(0, 2));
    drain();
  endtask

  // Random sets, mostly small with varied spreads, under random idling and
  // one stretch without any stalls.
  task automatic test_random_sets();
    int sent;
    int n;
    sent = 0;
    while (sent < 130) begin
      if (($urandom_range(0, 9)) == 0) begin
        drain();
        write_top_count(3'($urandom_range(0, 7)));
      end
      stall_out = (sent < 50 || sent > 90);
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 64) : $urandom_range(1, 8);
      case ($urandom_range(0, 2))
        0: send_random_set(n, 64, stall_out);
        1: send_random_set(n, 1200, stall_out);
        default: send_random_set(n, 32768, stall_out);
      endcase
      sent += n;
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    logit_ch.valid = 1'b0;
    logit_ch.logit_value = '0;
    logit_ch.last_logit = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    set_size = 0;
    rank_limit = 3'd5;
    error_count = 0;
    cycle_count = 0;
    stall_out = 1'b1;
    repeat (8) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
    test_directed_extremes();
    test_top_count_settings();
    test_store_overflow();
    test_random_sets();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
